[sv/assert_macros.svh]
// Assertion macros for the RTL of the cluster chain walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Implication checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/fat12ccw_pkg.sv]
// Types and constants of the FAT12 cluster chain walker.
package fat12ccw_pkg;

  // Allocation table size in bytes and derived address widths.
  localparam int unsigned TABLE_BYTES = 8192;
  localparam int unsigned TBL_AW      = $clog2(TABLE_BYTES);
  localparam int unsigned OFF_W       = TBL_AW + 1;

  // Field widths.
  localparam int unsigned CLUS_W = 12;
  localparam int unsigned LBA_W  = 32;
  localparam int unsigned SPC_W  = 8;
  localparam int unsigned CNT_W  = $clog2(SPC_W);

  // Entries at or above this value end a chain.
  localparam logic [CLUS_W-1:0] END_MARK = 12'hFF8;

  // Item selector codes.
  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_START   = 2'd1,
    FUNC_ADVANCE = 2'd2
  } func_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_LBA = 1'b0,
    REG_SPC = 1'b1
  } reg_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WALK   = 2'd1,
    ST_FINISH = 2'd2
  } state_e;

  // Kind of result produced for the current item.
  typedef enum logic [1:0] {
    RES_ZERO    = 2'd0,
    RES_NOCHAIN = 2'd1,
    RES_WALK    = 2'd2
  } res_kind_e;

  typedef struct packed {
    func_e              func;
    logic [TBL_AW-1:0]  table_addr;
    logic [7:0]         table_byte;
    logic [CLUS_W-1:0]  start_cluster;
  } in_item_t;

  typedef struct packed {
    logic [LBA_W-1:0]   sector_lba;
    logic [CLUS_W-1:0]  cur_cluster;
    logic [CLUS_W-1:0]  next_cluster;
    logic               last;
    logic               no_chain;
  } out_item_t;

  // Control into and status out of the sector address unit.
  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

[sv/fat12ccw_sec_unit.sv]
// Shift-and-add unit that forms a cluster's first sector one multiplier bit at a time.
module fat12ccw_sec_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fat12ccw_pkg::mul_ctl_t               ctl_i,
  input  logic [fat12ccw_pkg::CLUS_W-1:0]      clus_i,
  input  logic [fat12ccw_pkg::LBA_W-1:0]       lba_i,
  input  logic [fat12ccw_pkg::SPC_W-1:0]       spc_i,
  output fat12ccw_pkg::mul_sts_t               sts_o,
  output logic [fat12ccw_pkg::LBA_W-1:0]       sector_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [fat12ccw_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [fat12ccw_pkg::LBA_W-1:0]    acc_q, acc_d;
  logic [fat12ccw_pkg::LBA_W-1:0]    mcand_q, mcand_d;
  logic [fat12ccw_pkg::SPC_W-1:0]    mplier_q, mplier_d;
  logic [fat12ccw_pkg::LBA_W-1:0]    addend;

  // One multiplier bit per cycle through the accumulator adder.
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    addend   = mplier_q[0] ? mcand_q : '0;
    if (ctl_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = lba_i;
      mcand_d  = fat12ccw_pkg::LBA_W'(clus_i) - fat12ccw_pkg::LBA_W'(2);
      mplier_d = spc_i;
    end else if (busy_q) begin
      acc_d    = acc_q + addend;
      mcand_d  = {mcand_q[fat12ccw_pkg::LBA_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[fat12ccw_pkg::SPC_W-1:1]};
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == fat12ccw_pkg::CNT_W'(fat12ccw_pkg::SPC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sector_o   = acc_q;

endmodule

[sv/fat12_cluster_chain_walker.sv]
// A walk item's result is registered after the walk and finish states; other items skip the walk state.
// Throughput: one item at a time; input stalls until the result enters the output register.
// The sector address comes from an 8-step shift-and-add unit; table reads use one RAM port.
// Reset clears the sequencer, chain state and registers (sectors per cluster to 1);
// the allocation table is not cleared and holds undefined data until written.
`include "assert_macros.svh"

module fat12_cluster_chain_walker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Item input channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  fat12ccw_pkg::in_item_t  in_data_i,
  // Result output channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output fat12ccw_pkg::out_item_t out_data_o,
  // Configuration port.
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  fat12ccw_pkg::state_e                 state_q, state_d;
  fat12ccw_pkg::res_kind_e              kind_q, kind_d;
  logic [fat12ccw_pkg::CLUS_W-1:0]      clus_q, clus_d;
  logic [fat12ccw_pkg::OFF_W-1:0]       off_q, off_d;
  logic [1:0]                           step_q, step_d;
  logic [7:0]                           lo_q, lo_d, hi_q, hi_d;
  logic [fat12ccw_pkg::CLUS_W-1:0]      pending_q, pending_d;
  logic                                 active_q, active_d;
  logic                                 out_valid_q, out_valid_d;
  fat12ccw_pkg::out_item_t              out_q, out_d;
  logic [fat12ccw_pkg::LBA_W-1:0]       lba_q;
  logic [fat12ccw_pkg::SPC_W-1:0]       spc_q;

  logic                                 in_accept;
  logic                                 load_out;
  logic                                 cfg_write;
  logic                                 mem_we;
  logic [fat12ccw_pkg::OFF_W-1:0]       rd_addr;
  logic                                 rd_ok;
  logic                                 rd_ok_q;
  logic [7:0]                           mem_rdata_q;
  logic [7:0]                           mem_q [fat12ccw_pkg::TABLE_BYTES];
  logic [15:0]                          pair;
  logic [fat12ccw_pkg::CLUS_W-1:0]      entry;
  logic                                 last_c;
  logic [fat12ccw_pkg::CLUS_W-1:0]      walk_clus;
  fat12ccw_pkg::mul_ctl_t               mul_ctl;
  fat12ccw_pkg::mul_sts_t               mul_sts;
  logic [fat12ccw_pkg::LBA_W-1:0]       sector;

  assign in_stall_o  = (state_q != fat12ccw_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers; a write completes in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba_q <= '0;
      spc_q <= fat12ccw_pkg::SPC_W'(1);
    end else if (cfg_write) begin
      case (fat12ccw_pkg::reg_e'(paddr[2]))
        fat12ccw_pkg::REG_LBA: lba_q <= pwdata;
        fat12ccw_pkg::REG_SPC: spc_q <= pwdata[fat12ccw_pkg::SPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (fat12ccw_pkg::reg_e'(paddr[2]))
      fat12ccw_pkg::REG_LBA: prdata = lba_q;
      fat12ccw_pkg::REG_SPC: prdata = 32'(spc_q);
      default:               prdata = '0;
    endcase
  end

  // Allocation table: one write and one registered read per cycle.
  assign mem_we  = in_accept && (in_data_i.func == fat12ccw_pkg::FUNC_WRITE) &&
                   ({1'b0, in_data_i.table_addr} < fat12ccw_pkg::OFF_W'(fat12ccw_pkg::TABLE_BYTES));
  assign rd_addr = (step_q == 2'd0) ? off_q : off_q + 1'b1;
  assign rd_ok   = rd_addr < fat12ccw_pkg::OFF_W'(fat12ccw_pkg::TABLE_BYTES);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[in_data_i.table_addr] <= in_data_i.table_byte;
    end
    mem_rdata_q <= mem_q[rd_addr[fat12ccw_pkg::TBL_AW-1:0]];
    rd_ok_q     <= rd_ok;
  end

  // Decode the 12-bit entry from the byte pair.
  assign pair   = {hi_q, lo_q};
  assign entry  = clus_q[0] ? pair[15:4] : pair[11:0];
  assign last_c = (entry >= fat12ccw_pkg::END_MARK);

  assign walk_clus = (in_data_i.func == fat12ccw_pkg::FUNC_START) ? in_data_i.start_cluster
                                                                  : pending_q;

  // Sequencer: accept, fetch two bytes for a walk while the sector unit runs, then deliver.
  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    clus_d        = clus_q;
    off_d         = off_q;
    step_d        = step_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    pending_d     = pending_q;
    active_d      = active_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    mul_ctl.start = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      fat12ccw_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = fat12ccw_pkg::ST_FINISH;
          kind_d  = fat12ccw_pkg::RES_ZERO;
          if ((in_data_i.func == fat12ccw_pkg::FUNC_START) ||
              ((in_data_i.func == fat12ccw_pkg::FUNC_ADVANCE) && active_q)) begin
            state_d       = fat12ccw_pkg::ST_WALK;
            kind_d        = fat12ccw_pkg::RES_WALK;
            clus_d        = walk_clus;
            off_d         = fat12ccw_pkg::OFF_W'(walk_clus) +
                            fat12ccw_pkg::OFF_W'(walk_clus >> 1);
            step_d        = 2'd0;
            mul_ctl.start = 1'b1;
          end else if (in_data_i.func == fat12ccw_pkg::FUNC_ADVANCE) begin
            kind_d = fat12ccw_pkg::RES_NOCHAIN;
          end
        end
      end
      fat12ccw_pkg::ST_WALK: begin
        if (step_q != 2'd3) begin
          step_d = step_q + 1'b1;
        end
        if (step_q == 2'd1) begin
          lo_d = rd_ok_q ? mem_rdata_q : 8'd0;
        end
        if (step_q == 2'd2) begin
          hi_d = rd_ok_q ? mem_rdata_q : 8'd0;
        end
        if (mul_sts.done) begin
          state_d = fat12ccw_pkg::ST_FINISH;
        end
      end
      fat12ccw_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = fat12ccw_pkg::ST_IDLE;
          out_d       = '0;
          case (kind_q)
            fat12ccw_pkg::RES_WALK: begin
              out_d.sector_lba   = sector;
              out_d.cur_cluster  = clus_q;
              out_d.next_cluster = entry;
              out_d.last         = last_c;
              pending_d          = entry;
              active_d           = !last_c;
            end
            fat12ccw_pkg::RES_NOCHAIN: out_d.no_chain = 1'b1;
            default: ;
          endcase
        end
      end
      default: state_d = fat12ccw_pkg::ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fat12ccw_pkg::ST_IDLE;
      kind_q      <= fat12ccw_pkg::RES_ZERO;
      step_q      <= 2'd0;
      pending_q   <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      step_q      <= step_d;
      pending_q   <= pending_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    clus_q <= clus_d;
    off_q  <= off_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    out_q  <= out_d;
  end

  // Sector address unit.
  fat12ccw_sec_unit u_sec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mul_ctl),
    .clus_i   (clus_d),
    .lba_i    (lba_q),
    .spc_i    (spc_q),
    .sts_o    (mul_sts),
    .sector_o (sector)
  );

  // The sector unit is never running while the block waits for an item.
  `ASSERT_CLK(a_unit_idle, (state_q == fat12ccw_pkg::ST_IDLE) |-> !mul_sts.busy, "sector unit busy in idle")
  // Completion of the sector unit moves the sequencer on to delivery.
  `ASSERT_CLK(a_done_finish, (state_q == fat12ccw_pkg::ST_WALK && mul_sts.done) |=> (state_q == fat12ccw_pkg::ST_FINISH), "walk did not finish")
  // A result flagged last closes the chain.
  `ASSERT_CLK(a_last_closes, (load_out && kind_q == fat12ccw_pkg::RES_WALK && last_c) |=> !active_q, "chain still open after last")
  // A no-chain result is only produced when no chain is open.
  `ASSERT_CLK(a_nochain_idle, (load_out && kind_q == fat12ccw_pkg::RES_NOCHAIN) |-> !active_q, "no-chain flagged with open chain")
  // Walk reads are complete before the sector unit reports done.
  `ASSERT_CLK(a_reads_first, (state_q == fat12ccw_pkg::ST_WALK && mul_sts.done) |-> (step_q == 2'd3), "table reads unfinished")

endmodule

[test/tb_fat12_cluster_chain_walker.sv]
// Self-checking testbench for the FAT12 cluster chain walker.
module tb_fat12_cluster_chain_walker;

  // Selector value with no function assigned; the block returns an all-zero result for it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Table bytes covered by cluster entries 0 to 4095.
  localparam int unsigned ENTRY_BYTES = 6144;
  // Low clusters that are loaded and walked; their entries take three bytes per pair.
  localparam int unsigned LOAD_CLUSTERS = 128;
  localparam int unsigned LOAD_BYTES    = LOAD_CLUSTERS * 3 / 2;
  // Top clusters that are loaded as well, so that the highest clusters can be walked.
  localparam int unsigned TOP_CLUSTER = 4080;
  localparam int unsigned TOP_BYTE    = TOP_CLUSTER * 3 / 2;
  // Cycles allowed to settle after the last result before a register write.
  localparam int unsigned SETTLE_CYCLES = 12;
  // Cycles without any transfer before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 2000;

  // Predicts every result of the walker and compares the ones it delivers.
  class chain_scoreboard;
    logic [7:0]                      fat_bytes [fat12ccw_pkg::TABLE_BYTES];
    logic [fat12ccw_pkg::CLUS_W-1:0] follow_cluster;
    bit                              chain_open;
    logic [31:0]                     region_lba;
    logic [7:0]                      sec_per_clus;
    fat12ccw_pkg::out_item_t         awaited_q [$];
    int                              errors;
    int                              n_writes, n_steps, n_ends, n_orphans, n_regs;

    function new();
      follow_cluster = '0;
      chain_open     = 1'b0;
      region_lba     = '0;
      sec_per_clus   = 8'd1;
    endfunction

    function void set_reg(fat12ccw_pkg::reg_e idx, logic [31:0] val);
      n_regs++;
      if (idx == fat12ccw_pkg::REG_LBA) region_lba = val;
      else sec_per_clus = val[7:0];
    endfunction

    function logic [7:0] fat_byte(int unsigned off);
      return (off < fat12ccw_pkg::TABLE_BYTES) ? fat_bytes[off] : 8'h00;
    endfunction

    // The 12-bit entry of a cluster, read little-endian from two bytes.
    function logic [fat12ccw_pkg::CLUS_W-1:0] entry_of(logic [fat12ccw_pkg::CLUS_W-1:0] clus);
      int unsigned off;
      logic [15:0] pair;
      off  = int'(clus) * 3 / 2;
      pair = {fat_byte(off + 1), fat_byte(off)};
      return clus[0] ? pair[15:4] : pair[11:0];
    endfunction

    // Result of visiting one cluster; also moves the chain on.
    function fat12ccw_pkg::out_item_t visit(logic [fat12ccw_pkg::CLUS_W-1:0] clus);
      fat12ccw_pkg::out_item_t r;
      r              = '0;
      r.cur_cluster  = clus;
      r.next_cluster = entry_of(clus);
      r.last         = (r.next_cluster >= fat12ccw_pkg::END_MARK);
      r.sector_lba   = region_lba + ({20'd0, clus} - 32'd2) * {24'd0, sec_per_clus};
      follow_cluster = r.next_cluster;
      chain_open     = !r.last;
      n_steps++;
      if (r.last) n_ends++;
      return r;
    endfunction

    // Called for every item taken by the block.
    function void note_item(fat12ccw_pkg::in_item_t it);
      fat12ccw_pkg::out_item_t r;
      r = '0;
      case (it.func)
        fat12ccw_pkg::FUNC_WRITE: begin
          fat_bytes[it.table_addr] = it.table_byte;
          n_writes++;
        end
        fat12ccw_pkg::FUNC_START: r = visit(it.start_cluster);
        fat12ccw_pkg::FUNC_ADVANCE: begin
          if (chain_open) begin
            r = visit(follow_cluster);
          end else begin
            r.no_chain = 1'b1;
            n_orphans++;
          end
        end
        default: ;
      endcase
      awaited_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Called for every result taken from the block.
    task check_result(fat12ccw_pkg::out_item_t got);
      fat12ccw_pkg::out_item_t want;
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = awaited_q.pop_front();
        if (got.sector_lba !== want.sector_lba)
          report_mismatch($sformatf("sector_lba %h, predicted %h (cluster %h)",
                                    got.sector_lba, want.sector_lba, want.cur_cluster));
        if (got.cur_cluster !== want.cur_cluster)
          report_mismatch($sformatf("cur_cluster %h, predicted %h",
                                    got.cur_cluster, want.cur_cluster));
        if (got.next_cluster !== want.next_cluster)
          report_mismatch($sformatf("next_cluster %h, predicted %h (cluster %h)",
                                    got.next_cluster, want.next_cluster, want.cur_cluster));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, predicted %b", got.last, want.last));
        if (got.no_chain !== want.no_chain)
          report_mismatch($sformatf("no_chain %b, predicted %b", got.no_chain, want.no_chain));
      end
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  fat12ccw_pkg::in_item_t  in_data_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  fat12ccw_pkg::out_item_t out_data_o;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [2:0]              paddr       = '0;
  logic [31:0]             pwdata      = '0;
  logic [31:0]             prdata;
  logic                    pready;

  chain_scoreboard sb = new();
  bit              idle_on   = 1'b0;
  bit              run_live  = 1'b0;
  int              stall_left;

  fat12_cluster_chain_walker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: check each transfer, then decide the stall for the next cycle.
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog: give up when no transfer has happened for too long.
  initial begin
    int quiet;
    quiet = 0;
    wait (run_live);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Timed out after %0d cycles without a transfer.", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one item and waits for its transfer; valid stays high afterwards.
  task send_item(fat12ccw_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  function fat12ccw_pkg::in_item_t make_item(fat12ccw_pkg::func_e f, int unsigned addr,
                                             int unsigned val, int unsigned clus);
    fat12ccw_pkg::in_item_t it;
    it.func          = f;
    it.table_addr    = addr[fat12ccw_pkg::TBL_AW-1:0];
    it.table_byte    = val[7:0];
    it.start_cluster = clus[fat12ccw_pkg::CLUS_W-1:0];
    return it;
  endfunction

  // An entry that stays inside the loaded clusters, or one of the end marks.
  function logic [fat12ccw_pkg::CLUS_W-1:0] random_entry();
    if ($urandom_range(0, 7) == 0)
      return fat12ccw_pkg::END_MARK + fat12ccw_pkg::CLUS_W'($urandom_range(0, 7));
    return fat12ccw_pkg::CLUS_W'($urandom_range(0, LOAD_CLUSTERS - 1));
  endfunction

  // A cluster whose entry bytes have been loaded.
  function int unsigned pick_cluster();
    if ($urandom_range(0, 7) == 0) return $urandom_range(TOP_CLUSTER, 4095);
    return $urandom_range(0, LOAD_CLUSTERS - 1);
  endfunction

  // A table byte that no walk ever reads.
  function int unsigned spare_addr();
    if ($urandom_range(0, 1) == 0) return $urandom_range(LOAD_BYTES, TOP_BYTE - 1);
    return $urandom_range(ENTRY_BYTES, fat12ccw_pkg::TABLE_BYTES - 1);
  endfunction

  // All fields random; the caller picks the function.
  function fat12ccw_pkg::in_item_t random_fields(fat12ccw_pkg::func_e f);
    return make_item(f, spare_addr(), $urandom_range(0, 255), pick_cluster());
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task program_reg(fat12ccw_pkg::reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
  endtask

  task configure(logic [31:0] lba, logic [7:0] spc);
    program_reg(fat12ccw_pkg::REG_LBA, lba);
    program_reg(fat12ccw_pkg::REG_SPC, {24'd0, spc});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every predicted result has been delivered, then let the block settle.
  task drain_results();
    in_valid_i <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Loads the low and the top clusters with chains of random length, plus fixed
  // entries for the directed walks: 2 -> 3 -> 4 -> end, 5 on the end mark, 6 just
  // below it. Every loaded entry points back into the loaded clusters or ends.
  task load_allocation_table();
    logic [fat12ccw_pkg::CLUS_W-1:0] ent;
    logic [7:0]                      img [ENTRY_BYTES];
    int unsigned                     off;
    for (int c = 0; c < 4096; c++) begin
      ent = random_entry();
      case (c)
        1, 4: ent = 12'hFFF;
        2:    ent = 12'd3;
        3:    ent = 12'd4;
        5:    ent = fat12ccw_pkg::END_MARK;
        6:    ent = fat12ccw_pkg::END_MARK - 12'd1;
        default: ;
      endcase
      off = c * 3 / 2;
      if (c % 2 == 0) begin
        img[off]          = ent[7:0];
        img[off + 1][3:0] = ent[11:8];
      end else begin
        img[off][7:4]     = ent[3:0];
        img[off + 1]      = ent[11:4];
      end
    end
    for (int a = 0; a < LOAD_BYTES; a++)
      send_item(make_item(fat12ccw_pkg::FUNC_WRITE, a, 32'(img[a]), $urandom_range(0, 4095)));
    for (int a = TOP_BYTE; a < ENTRY_BYTES; a++)
      send_item(make_item(fat12ccw_pkg::FUNC_WRITE, a, 32'(img[a]), $urandom_range(0, 4095)));
  endtask

  // Replaces one loaded entry by two byte writes, keeping the neighbour's nibble.
  task rewrite_entry();
    int unsigned                     clus;
    logic [fat12ccw_pkg::CLUS_W-1:0] ent;
    int unsigned                     off;
    logic [7:0]                      b0;
    logic [7:0]                      b1;
    clus = pick_cluster();
    ent  = random_entry();
    off  = clus * 3 / 2;
    b0   = sb.fat_byte(off);
    b1   = sb.fat_byte(off + 1);
    if (clus % 2 == 1) begin
      b0[7:4] = ent[3:0];
      b1      = ent[11:4];
    end else begin
      b0      = ent[7:0];
      b1[3:0] = ent[11:8];
    end
    send_item(make_item(fat12ccw_pkg::FUNC_WRITE, off, 32'(b0), $urandom_range(0, 4095)));
    send_item(make_item(fat12ccw_pkg::FUNC_WRITE, off + 1, 32'(b1), $urandom_range(0, 4095)));
  endtask

  // Corner cases: orphan advances, chain end, end mark boundary, wrap of the
  // sector address for clusters 0 and 1, the top cluster, restart of an open
  // chain, the top table address and the unused selector.
  task directed_items();
    fat12ccw_pkg::in_item_t junk;
    send_item(make_item(fat12ccw_pkg::FUNC_ADVANCE, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 2));
    send_item(make_item(fat12ccw_pkg::FUNC_ADVANCE, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_ADVANCE, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_ADVANCE, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 5));
    send_item(make_item(fat12ccw_pkg::FUNC_ADVANCE, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 6));
    send_item(make_item(fat12ccw_pkg::FUNC_ADVANCE, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 1));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 4095));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 2));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 6));
    send_item(make_item(fat12ccw_pkg::FUNC_WRITE, fat12ccw_pkg::TABLE_BYTES - 1, 8'hFF, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_WRITE, 0, 8'h00, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_WRITE, ENTRY_BYTES - 1, 8'hFF, 4095));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 0));
    send_item(make_item(fat12ccw_pkg::FUNC_START, 0, 0, 4095));
    junk = make_item(fat12ccw_pkg::FUNC_WRITE, fat12ccw_pkg::TABLE_BYTES - 1, 8'hFF, 4095);
    junk.func = fat12ccw_pkg::func_e'(FUNC_UNUSED);
    send_item(junk);
    send_item(make_item(fat12ccw_pkg::FUNC_ADVANCE, fat12ccw_pkg::TABLE_BYTES - 1, 8'hFF, 4095));
  endtask

  // Mostly chain walks with random start and length; the rest is entry
  // rewrites, spare table writes, stray advances and unused selectors.
  task random_items(int count);
    int                     sent;
    int                     pick;
    fat12ccw_pkg::in_item_t it;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_item(random_fields(fat12ccw_pkg::FUNC_START));
        sent++;
        repeat ($urandom_range(0, 10)) begin
          send_item(random_fields(fat12ccw_pkg::FUNC_ADVANCE));
          sent++;
        end
      end else if (pick < 75) begin
        rewrite_entry();
        sent += 2;
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(random_fields(fat12ccw_pkg::FUNC_WRITE));
          sent++;
        end
      end else if (pick < 95) begin
        send_item(random_fields(fat12ccw_pkg::FUNC_ADVANCE));
        sent++;
      end else begin
        it = random_fields(fat12ccw_pkg::FUNC_WRITE);
        it.func = fat12ccw_pkg::func_e'(FUNC_UNUSED);
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] lba_set  [6];
    logic [7:0]  spc_set  [6];
    bit          idle_set [6];
    lba_set  = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0000, $urandom, $urandom};
    spc_set  = '{8'd1, 8'd128, 8'($urandom_range(1, 128)), 8'd255, 8'd0,
                 8'($urandom_range(2, 127))};
    idle_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    repeat (9) @(posedge clk_i);
    rst_ni   <= 1'b1;
    run_live  = 1'b1;
    @(posedge clk_i);

    configure(32'd1000, 8'd4);
    load_allocation_table();
    idle_on = 1'b1;
    directed_items();

    for (int p = 0; p < 6; p++) begin
      drain_results();
      configure(lba_set[p], spc_set[p]);
      idle_on = idle_set[p];
      random_items(100);
    end

    drain_results();
    $display("Covered %0d table writes and %0d cluster visits, %0d of them chain ends.",
             sb.n_writes, sb.n_steps, sb.n_ends);
    $display("Saw %0d advances without a chain over %0d register writes.",
             sb.n_orphans, sb.n_regs);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches.", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[fat12_cluster_chain_walker.f]
+incdir+sv
sv/fat12ccw_pkg.sv
sv/fat12ccw_sec_unit.sv
sv/fat12_cluster_chain_walker.sv
test/tb_fat12_cluster_chain_walker.sv
